// ----- sv/hsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_pkg
// shared types and constants of the huffman stream decoder
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int BYTE_BITS = 8;
  localparam int SYM_BITS  = 8;
  localparam int CNT_BITS  = $clog2(BYTE_BITS);

  // one result transaction
  typedef struct packed {
    logic [SYM_BITS-1:0] sym;
    logic                eos;
    logic                err;
  } res_t;

  // status of the serial bit shifter
  typedef struct packed {
    logic bit_val;
    logic last;
  } shift_status_t;

endpackage

// ----- sv/huffman_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_stream_decoder_core
// huffman decoder with a preorder tree header, one bit per step
// ----------------------------------------------------------------------------
// throughput: one byte at a time, with an accept step, a bit step per bit
//   and an end of byte step; a tree bit adds a pop step when a pop uncovers
//   an entry stored below the top of stack, a decode bit a leaf read step,
//   after a right child read step for a right step, set by the registered
//   reads of the child and leaf rams, and a result an emit step, which waits
//   while the hold and output registers are full; the end of byte step moves
//   the last result of a byte to the output register once it is free
// reset: synchronous active low, returns to tree loading with an empty tree;
//   ram contents are not cleared
// ----------------------------------------------------------------------------
module huffman_stream_decoder_core #(
  parameter int MAX_NODES   = 1024,
  parameter int STACK_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // compressed byte input
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] start_of_stream
  // decoded result output
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] symbol
  output logic [1:0] out_tuser,  // [0] end_of_stream, [1] error_flag
  output logic       out_tlast   // last_of_run
);

  localparam int NIDX = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int SB   = hsd_pkg::SYM_BITS;

  typedef enum logic [2:0] {
    S_IN, S_BIT, S_RD1, S_RD2, S_POP, S_EMIT, S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_LOAD, PH_FIND, PH_DECODE, PH_HALT
  } phase_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [NCW-1:0]      nc_r, nc_nxt;
  logic [SPW-1:0]      sp_r, sp_nxt;
  logic [NIDX-1:0]     top_idx_r, top_idx_nxt;   // stack top kept in flops
  logic                top_flg_r, top_flg_nxt;   // left child already taken
  logic [NIDX-1:0]     cur_r, cur_nxt;
  logic [NIDX-1:0]     c_r, c_nxt;
  logic [SB-1:0]       sym_sh_r, sym_sh_nxt;
  logic [3:0]          sym_left_r, sym_left_nxt;
  logic                root_leaf_r, root_leaf_nxt;
  logic [NIDX-1:0]     end_idx_r, end_idx_nxt;   // end marker leaf
  hsd_pkg::res_t       res_r, res_nxt;
  logic                pend_v_r, pend_v_nxt;     // result held back for tlast
  hsd_pkg::res_t       pend_r, pend_nxt;
  logic                out_v_r, out_v_nxt;
  hsd_pkg::res_t       out_r, out_nxt;
  logic                out_last_r, out_last_nxt;

  // ram ports
  logic                info_we;
  logic [NIDX-1:0]     info_waddr, info_raddr;
  logic [SB:0]         info_wdata, info_rdata;   // {leaf, symbol}
  logic                right_we;
  logic [NIDX-1:0]     right_waddr, right_raddr, right_wdata, right_rdata;
  logic                stk_we;
  logic [SAW-1:0]      stk_waddr, stk_raddr;
  logic [NIDX:0]       stk_wdata, stk_rdata;     // {left taken, index}

  logic                  sh_load, sh_adv;
  hsd_pkg::shift_status_t sh_st;

  hsd_bit_shifter u_shift (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (sh_load),
    .adv     (sh_adv),
    .byte_in (in_tdata),
    .status  (sh_st)
  );

  // leaf flag and symbol of each node
  hsd_ram #(.WIDTH(SB + 1), .DEPTH(MAX_NODES)) u_info (
    .clk (clk), .we (info_we), .waddr (info_waddr), .wdata (info_wdata),
    .raddr (info_raddr), .rdata (info_rdata)
  );

  // right child of each internal node; the left child is always the next node
  hsd_ram #(.WIDTH(NIDX), .DEPTH(MAX_NODES)) u_right (
    .clk (clk), .we (right_we), .waddr (right_waddr), .wdata (right_wdata),
    .raddr (right_raddr), .rdata (right_rdata)
  );

  // pending internal nodes below the top of stack
  hsd_ram #(.WIDTH(NIDX + 1), .DEPTH(STACK_DEPTH)) u_stack (
    .clk (clk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
    .raddr (stk_raddr), .rdata (stk_rdata)
  );

  assign in_tready = (state_r == S_IN);

  always_comb begin
    logic          go_next;
    logic          popped;
    logic [NIDX-1:0] n_idx;
    logic [3:0]    left_dec;
    logic [SB-1:0] sh_new;
    go_next      = 1'b0;
    popped       = 1'b0;
    n_idx        = nc_r[NIDX-1:0];
    left_dec     = sym_left_r - 4'd1;
    sh_new       = {sym_sh_r[SB-2:0], sh_st.bit_val};
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    nc_nxt       = nc_r;
    sp_nxt       = sp_r;
    top_idx_nxt  = top_idx_r;
    top_flg_nxt  = top_flg_r;
    cur_nxt      = cur_r;
    c_nxt        = c_r;
    sym_sh_nxt   = sym_sh_r;
    sym_left_nxt = sym_left_r;
    root_leaf_nxt = root_leaf_r;
    end_idx_nxt  = end_idx_r;
    res_nxt      = res_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    info_we      = 1'b0;
    info_waddr   = n_idx;
    info_wdata   = '0;
    info_raddr   = cur_r;
    right_we     = 1'b0;
    right_waddr  = top_idx_r;
    right_wdata  = n_idx;
    right_raddr  = cur_r;
    stk_we       = 1'b0;
    stk_waddr    = SAW'(sp_r - SPW'(1));
    stk_wdata    = {1'b1, top_idx_r};
    stk_raddr    = SAW'(sp_r - SPW'(2));
    sh_load      = 1'b0;
    sh_adv       = 1'b0;

    // output register drains independently
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IN: begin
        if (in_tvalid) begin
          sh_load   = 1'b1;
          state_nxt = S_BIT;
          if (in_tuser[0]) begin
            phase_nxt    = PH_LOAD;
            nc_nxt       = '0;
            sp_nxt       = '0;
            cur_nxt      = '0;
            sym_left_nxt = '0;
            sym_sh_nxt   = '0;
          end
        end
      end
      S_BIT: begin
        unique case (phase_r)
          PH_LOAD: begin
            if (sym_left_r != 4'd0) begin
              // symbol bit of the latest leaf
              sym_sh_nxt   = sh_new;
              sym_left_nxt = left_dec;
              go_next      = 1'b1;
              if (left_dec == 4'd0) begin
                info_we    = 1'b1;
                info_waddr = NIDX'(nc_r - NCW'(1));
                info_wdata = {1'b1, sh_new};
                if (sp_r == '0) begin
                  // tree complete
                  cur_nxt = '0;
                  if (root_leaf_r) begin
                    phase_nxt = PH_HALT;
                    res_nxt   = '{sym: '0, eos: 1'b1, err: 1'b0};
                    state_nxt = S_EMIT;
                    go_next   = 1'b0;
                  end else begin
                    phase_nxt = PH_FIND;
                  end
                end
              end
            end else if (nc_r >= NCW'(MAX_NODES)) begin
              phase_nxt = PH_HALT;
              res_nxt   = '{sym: '0, eos: 1'b0, err: 1'b1};
              state_nxt = S_EMIT;
            end else begin
              nc_nxt     = nc_r + NCW'(1);
              info_we    = 1'b1;
              info_wdata = {sh_st.bit_val, {SB{1'b0}}};
              if (nc_r == '0) begin
                root_leaf_nxt = sh_st.bit_val;
              end
              // attach new node to the parent on top of stack
              if (sp_r != '0) begin
                if (!top_flg_r) begin
                  top_flg_nxt = 1'b1;
                end else begin
                  right_we = 1'b1;
                  popped   = 1'b1;
                end
              end
              if (!sh_st.bit_val) begin
                if (!popped && sp_r >= SPW'(STACK_DEPTH)) begin
                  phase_nxt = PH_HALT;
                  res_nxt   = '{sym: '0, eos: 1'b0, err: 1'b1};
                  state_nxt = S_EMIT;
                end else begin
                  // push: pop and push in one step leaves the depth unchanged
                  if (!popped) begin
                    stk_we = (sp_r != '0);
                    sp_nxt = sp_r + SPW'(1);
                  end
                  top_idx_nxt = n_idx;
                  top_flg_nxt = 1'b0;
                  go_next     = 1'b1;
                end
              end else begin
                sym_left_nxt = 4'(SB);
                sym_sh_nxt   = '0;
                if (popped) begin
                  sp_nxt = sp_r - SPW'(1);
                  if (sp_r > SPW'(1)) begin
                    state_nxt = S_POP;
                  end else begin
                    go_next = 1'b1;
                  end
                end else begin
                  go_next = 1'b1;
                end
              end
            end
          end
          PH_FIND, PH_DECODE: begin
            if (sh_st.bit_val) begin
              state_nxt = S_RD1;
            end else begin
              c_nxt      = cur_r + NIDX'(1);
              info_raddr = cur_r + NIDX'(1);
              state_nxt  = S_RD2;
            end
          end
          default: begin
            go_next = 1'b1;
          end
        endcase
      end
      S_POP: begin
        top_idx_nxt = stk_rdata[NIDX-1:0];
        top_flg_nxt = stk_rdata[NIDX];
        go_next     = 1'b1;
      end
      S_RD1: begin
        c_nxt      = right_rdata;
        info_raddr = right_rdata;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        if (info_rdata[SB]) begin
          cur_nxt = '0;
          if (phase_r == PH_FIND) begin
            end_idx_nxt = c_r;
            phase_nxt   = PH_DECODE;
            go_next     = 1'b1;
          end else if (c_r == end_idx_r) begin
            phase_nxt = PH_HALT;
            res_nxt   = '{sym: '0, eos: 1'b1, err: 1'b0};
            state_nxt = S_EMIT;
          end else begin
            res_nxt   = '{sym: info_rdata[SB-1:0], eos: 1'b0, err: 1'b0};
            state_nxt = S_EMIT;
          end
        end else begin
          cur_nxt = c_r;
          go_next = 1'b1;
        end
      end
      S_EMIT: begin
        if (!pend_v_r) begin
          pend_nxt   = res_r;
          pend_v_nxt = 1'b1;
          go_next    = 1'b1;
        end else if (!out_v_r || out_tready) begin
          out_nxt      = pend_r;
          out_last_nxt = 1'b0;
          out_v_nxt    = 1'b1;
          pend_nxt     = res_r;
          go_next      = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IN;
        end else if (!out_v_r || out_tready) begin
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_IN;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase

    // move to the next bit of the byte, or close the byte
    if (go_next) begin
      sh_adv    = 1'b1;
      state_nxt = sh_st.last ? S_FLUSH : S_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      phase_r     <= PH_LOAD;
      nc_r        <= '0;
      sp_r        <= '0;
      cur_r       <= '0;
      sym_left_r  <= '0;
      sym_sh_r    <= '0;
      root_leaf_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      nc_r        <= nc_nxt;
      sp_r        <= sp_nxt;
      cur_r       <= cur_nxt;
      sym_left_r  <= sym_left_nxt;
      sym_sh_r    <= sym_sh_nxt;
      root_leaf_r <= root_leaf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
    top_idx_r  <= top_idx_nxt;
    top_flg_r  <= top_flg_nxt;
    c_r        <= c_nxt;
    end_idx_r  <= end_idx_nxt;
    res_r      <= res_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.sym;
  assign out_tuser  = {out_r.err, out_r.eos};
  assign out_tlast  = out_last_r;

  // a new byte is only taken once the held-back result has gone out
  a_ready_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_v_r) else $error("byte accepted with a result still held");

  // end and error never come together
  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1])) else $error("end and error both set");

  // counters stay within their stores
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");

  a_nc_range: assert property (@(posedge clk) disable iff (!rst_n)
    nc_r <= NCW'(MAX_NODES)) else $error("node count out of range");

endmodule

// ----- sv/hsd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hsd_bit_shifter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_bit_shifter
// holds the current byte and hands out its bits msb first
// ----------------------------------------------------------------------------
module hsd_bit_shifter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic                            adv,
  input  logic [hsd_pkg::BYTE_BITS-1:0]   byte_in,
  output hsd_pkg::shift_status_t          status
);

  logic [hsd_pkg::BYTE_BITS-1:0] sh_r;
  logic [hsd_pkg::CNT_BITS-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (load) begin
      sh_r <= byte_in;
    end else if (adv) begin
      sh_r <= {sh_r[hsd_pkg::BYTE_BITS-2:0], 1'b0};
    end
  end

  assign status.bit_val = sh_r[hsd_pkg::BYTE_BITS-1];
  assign status.last    = (cnt_r == hsd_pkg::CNT_BITS'(hsd_pkg::BYTE_BITS - 1));

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for huffman_stream_decoder_core: a directed table of
// byte transactions followed by randomly built streams (random trees, end
// markers and symbol runs, noise, stack overflow), each result transaction
// compared with an in-bench model of the decoder
// ----------------------------------------------------------------------------
module testbench;

  localparam int NODES      = 1024;
  localparam int STACK      = 256;
  localparam int QUIET_MAX  = 6000;
  localparam int HOLD_LEN   = 700;
  localparam int RAND_ITEMS = 250;

  typedef enum logic [1:0] {PH_LOAD, PH_FIND, PH_DECODE, PH_IDLE} phase_e;

  typedef struct packed {
    hsd_pkg::res_t r;
    logic          last;
  } dec_out_t;

  typedef struct {
    logic [7:0] data;
    bit         sos;
    int         n_typed;   // -1: model only, else typed count of results
    dec_out_t   typed;     // first typed result
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  always #10 clk = ~clk;

  huffman_stream_decoder_core #(.MAX_NODES(NODES), .STACK_DEPTH(STACK)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // --------------------------------------------------------------------------
  // decoder model state
  // --------------------------------------------------------------------------
  phase_e     dm_phase;
  int         nd_left  [NODES];
  int         nd_right [NODES];
  logic [7:0] nd_sym   [NODES];
  bit         nd_leaf  [NODES];
  bit         nd_end   [NODES];
  int         pend     [STACK];
  int         node_cnt, sp, cur, sym_bits_left;
  logic [7:0] sym_shift;

  dec_out_t   pending_results[$];
  byte_item_t byte_q[$];
  bit         bit_q[$];
  int         fail_cnt = 0;
  bit         hold_req = 1'b0;

  task automatic clear_decoder();
    dm_phase = PH_LOAD;
    for (int i = 0; i < NODES; i++) begin
      nd_left[i] = 0; nd_right[i] = 0; nd_sym[i] = '0;
      nd_leaf[i] = 0; nd_end[i] = 0;
    end
    node_cnt = 0; sp = 0; cur = 0; sym_bits_left = 0; sym_shift = '0;
  endtask

  function automatic dec_out_t mk_out(logic [7:0] s, logic e, logic x);
    dec_out_t o;
    o.r.sym = s; o.r.eos = e; o.r.err = x; o.last = 1'b0;
    return o;
  endfunction

  // one tree header bit
  task automatic tree_bit(input bit b, ref dec_out_t res[$]);
    int n, t;
    if (sym_bits_left > 0) begin
      sym_shift = {sym_shift[6:0], b};
      sym_bits_left--;
      if (sym_bits_left == 0) begin
        nd_sym[node_cnt-1] = sym_shift;
        if (sp == 0) begin
          // tree complete
          cur = 0;
          if (nd_leaf[0]) begin
            // root is a leaf, so it is the end marker itself
            nd_end[0] = 1;
            dm_phase = PH_IDLE;
            res.push_back(mk_out(8'h00, 1'b1, 1'b0));
          end else begin
            dm_phase = PH_FIND;
          end
        end
      end
      return;
    end
    if (node_cnt >= NODES) begin
      dm_phase = PH_IDLE;
      res.push_back(mk_out(8'h00, 1'b0, 1'b1));
      return;
    end
    n = node_cnt++;
    nd_left[n] = 0; nd_right[n] = 0; nd_sym[n] = '0; nd_leaf[n] = 0; nd_end[n] = 0;
    if (sp > 0) begin
      t = pend[sp-1];
      if (nd_left[t] == 0) nd_left[t] = n;
      else begin
        nd_right[t] = n;
        sp--;
      end
    end
    if (!b) begin
      if (sp >= STACK) begin
        dm_phase = PH_IDLE;
        res.push_back(mk_out(8'h00, 1'b0, 1'b1));
        return;
      end
      pend[sp++] = n;
    end else begin
      nd_leaf[n] = 1;
      sym_bits_left = hsd_pkg::SYM_BITS;
      sym_shift = '0;
    end
  endtask

  // expected results of one accepted byte transaction
  task automatic decode_byte(input logic [7:0] data, input bit sos, ref dec_out_t res[$]);
    int c;
    bit b;
    res = {};
    if (sos) clear_decoder();
    for (int i = 7; i >= 0; i--) begin
      b = data[i];
      case (dm_phase)
        PH_LOAD: tree_bit(b, res);
        PH_FIND: begin
          c = b ? nd_right[cur] : nd_left[cur];
          if (nd_leaf[c]) begin
            nd_end[c] = 1;
            cur = 0;
            dm_phase = PH_DECODE;
          end else cur = c;
        end
        PH_DECODE: begin
          c = b ? nd_right[cur] : nd_left[cur];
          if (nd_leaf[c]) begin
            if (nd_end[c]) begin
              dm_phase = PH_IDLE;
              res.push_back(mk_out(8'h00, 1'b1, 1'b0));
            end else begin
              res.push_back(mk_out(nd_sym[c], 1'b0, 1'b0));
              cur = 0;
            end
          end else cur = c;
        end
        default: ;
      endcase
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // stream building
  // --------------------------------------------------------------------------
  int         lf_code [64];
  int         lf_len  [64];
  logic [7:0] lf_sym  [64];
  int         lf_cnt;

  task automatic add_byte(logic [7:0] d, bit s, int n, dec_out_t t);
    byte_item_t it;
    it.data = d; it.sos = s; it.n_typed = n; it.typed = t;
    byte_q.push_back(it);
  endtask

  task automatic push_code(int code, int len);
    for (int i = len - 1; i >= 0; i--) bit_q.push_back(code[i]);
  endtask

  // pad to whole bytes with random bits and queue them, sos on the first
  task automatic flush_bits(bit sos);
    logic [7:0] d;
    bit first;
    first = sos;
    while (bit_q.size() % 8 != 0) bit_q.push_back(1'($urandom_range(0, 1)));
    while (bit_q.size() > 0) begin
      for (int i = 7; i >= 0; i--) d[i] = bit_q.pop_front();
      add_byte(d, first, -1, mk_out(0, 0, 0));
      first = 0;
    end
  endtask

  task automatic gen_tree(int code, int len);
    logic [7:0] s;
    if (len > 0 && (len >= 5 || $urandom_range(0, 2) == 0)) begin
      case ($urandom_range(0, 5))
        0: s = 8'hFF;
        1: s = 8'h00;
        default: s = 8'($urandom_range(0, 255));
      endcase
      bit_q.push_back(1'b1);
      push_code(int'(s), 8);
      lf_code[lf_cnt] = code; lf_len[lf_cnt] = len; lf_sym[lf_cnt] = s;
      lf_cnt++;
    end else begin
      bit_q.push_back(1'b0);
      gen_tree(code << 1, len + 1);
      gen_tree((code << 1) | 1, len + 1);
    end
  endtask

  // well formed stream: tree, end path, symbols, end code on nine streams in ten, trailing bytes
  task automatic gen_stream();
    int eidx, k, nsym;
    lf_cnt = 0;
    gen_tree(0, 0);
    eidx = $urandom_range(0, lf_cnt - 1);
    push_code(lf_code[eidx], lf_len[eidx]);
    nsym = $urandom_range(0, 24);
    for (int i = 0; i < nsym; i++) begin
      k = $urandom_range(0, lf_cnt - 1);
      if (k != eidx) push_code(lf_code[k], lf_len[k]);
    end
    if ($urandom_range(0, 9) != 0) push_code(lf_code[eidx], lf_len[eidx]);
    flush_bits(1);
    k = $urandom_range(0, 2);
    for (int i = 0; i < k; i++) add_byte(8'($urandom_range(0, 255)), 0, -1, mk_out(0, 0, 0));
  endtask

  task automatic build_stimulus();
    // no start after reset: root leaf 0xff, end on the ninth bit
    add_byte(8'hFF, 0, 0, mk_out(0, 0, 0));
    add_byte(8'h80, 0, 1, '{r: '{sym: 8'h00, eos: 1'b1, err: 1'b0}, last: 1'b1});
    // ignored after end
    add_byte(8'h55, 0, 0, mk_out(0, 0, 0));
    add_byte(8'h00, 0, 0, mk_out(0, 0, 0));
    // root leaf with start, symbol 0x7f
    add_byte(8'hBF, 1, 0, mk_out(0, 0, 0));
    add_byte(8'hC0, 0, 1, '{r: '{sym: 8'h00, eos: 1'b1, err: 1'b0}, last: 1'b1});
    // small tree: left 0xff, right (0x00, 0x5a end); decode ff 00 ff end
    push_code(0, 1); push_code(1, 1); push_code(8'hFF, 8);
    push_code(0, 1); push_code(1, 1); push_code(8'h00, 8);
    push_code(1, 1); push_code(8'h5A, 8);
    push_code(2'b11, 2);
    push_code(5'b01001, 5);
    push_code(2'b11, 2);
    flush_bits(1);
    // eight results from one byte: left leaf 0x33 repeated, the fourth byte
    // of the stream holds only left steps
    push_code(0, 1); push_code(1, 1); push_code(8'h33, 8);
    push_code(1, 1); push_code(8'hAA, 8);
    push_code(1, 1);
    push_code(12'h000, 12);
    push_code(1, 1);
    flush_bits(1);
    add_byte(8'hFF, 0, 0, mk_out(0, 0, 0));
  endtask

  task automatic build_random();
    int base;
    base = byte_q.size();
    // pending stack overflow: 257 internal nodes in a row
    add_byte(8'h00, 1, -1, mk_out(0, 0, 0));
    for (int i = 0; i < 33; i++) add_byte(8'h00, 0, -1, mk_out(0, 0, 0));
    while (byte_q.size() - base < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise bytes, start of stream at random
        for (int i = 0; i < $urandom_range(1, 4); i++)
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, -1,
                   mk_out(0, 0, 0));
      end else gen_stream();
    end
    gen_stream();
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic report(string what, dec_out_t e);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch %s: exp sym=%02h eos=%0b err=%0b last=%0b got sym=%02h eos=%0b err=%0b last=%0b",
               what, e.r.sym, e.r.eos, e.r.err, e.last,
               out_tdata, out_tuser[0], out_tuser[1], out_tlast);
  endtask

  always @(posedge clk) begin
    dec_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) report("unexpected", mk_out(0, 0, 0));
      else begin
        e = pending_results.pop_front();
        if (out_tdata !== e.r.sym || out_tuser[0] !== e.r.eos ||
            out_tuser[1] !== e.r.err || out_tlast !== e.last)
          report("field", e);
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: changing stall patterns, one long hold-off
  // --------------------------------------------------------------------------
  int  rx_cyc = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = HOLD_LEN;
    end
    rx_cyc++;
    if (rx_cyc % 60 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_cyc % 4 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // watchdog on cycles with no transaction on either side
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sender and end of run
  // --------------------------------------------------------------------------
  initial begin
    byte_item_t it;
    dec_out_t   res[$];
    int         burst, n_dir;
    clear_decoder();
    build_stimulus();
    n_dir = byte_q.size();
    build_random();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    burst = 0;
    for (int idx = 0; idx < byte_q.size(); idx++) begin
      it = byte_q[idx];
      if (idx == n_dir) hold_req = 1'b1;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst--;
      in_tvalid <= 1'b1;
      in_tdata  <= it.data;
      in_tuser  <= it.sos;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      decode_byte(it.data, it.sos, res);
      if (it.n_typed >= 0) begin
        if (res.size() != it.n_typed ||
            (it.n_typed > 0 && res[0] != it.typed)) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("directed row %0d: exp %0d results first %h, got %0d first %h",
                     idx, it.n_typed, it.typed, res.size(),
                     (res.size() > 0) ? res[0] : mk_out(0, 0, 0));
        end
      end
      foreach (res[i]) pending_results.push_back(res[i]);
    end
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- huffman_stream_decoder_core.f -----
sv/hsd_pkg.sv
sv/hsd_ram.sv
sv/hsd_bit_shifter.sv
sv/huffman_stream_decoder_core.sv
test/testbench.sv
